@@ sv/hiap_pkg.sv @@
// Shared types and constants for the HTML integer attribute parser.
package hiap_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned PROD_W      = 35;

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_KIND    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_VALUE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MINIMUM  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MAXIMUM  = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [PROD_W-1:0] SAT_LIMIT     = 35'h0_8000_0000;
  localparam logic [MAG_W-1:0]  SAT_MAG       = 32'h8000_0000;
  localparam logic [30:0]       CLAMP_MAX_RST = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_LONG             = 3'd0,
    KIND_LIMITED_LONG     = 3'd1,
    KIND_UNSIGNED         = 3'd2,
    KIND_LIMITED_UNSIGNED = 3'd3,
    KIND_FALLBACK_UNSIGNED = 3'd4,
    KIND_CLAMPED_UNSIGNED = 3'd5
  } kind_t;

  typedef struct packed {
    phase_t           phase;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             ovf;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic present;
  } fin_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fallback;
    logic [30:0] cmin;
    logic [30:0] cmax;
  } cfg_t;

endpackage

@@ sv/hiap_parse.sv @@
// Input register and per-byte parse state; hands the final state of a run to the judge.
module hiap_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic [1:0]        in_tuser,   // [0] char_valid, [1] attribute_present
  input  logic              in_tlast,   // is_last
  output hiap_pkg::fin_t    fin_r,
  output logic              fin_valid_r,
  input  logic              fin_ready
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_char_r;
  logic             s1_cvalid_r;
  logic             s1_present_r;
  logic             s1_last_r;
  hiap_pkg::pst_t   st_r, st_nxt, st_upd;
  hiap_pkg::fin_t   fin_nxt;
  logic             fin_valid_nxt;
  logic             in_fire, s1_go, fin_room, fin_take;
  logic             num_char, is_space;
  logic [3:0]       digit;
  logic [hiap_pkg::PROD_W-1:0] prod;
  hiap_pkg::pst_t   st_dig;

  assign fin_take  = fin_valid_r && fin_ready;
  assign fin_room  = !fin_valid_r || fin_ready;
  assign s1_go     = s1_valid_r && (!s1_last_r || fin_room);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign num_char = (s1_char_r >= hiap_pkg::CH_ZERO) && (s1_char_r <= hiap_pkg::CH_NINE);
  assign is_space = (s1_char_r == hiap_pkg::CH_TAB) || (s1_char_r == hiap_pkg::CH_LF) ||
                    (s1_char_r == hiap_pkg::CH_FF) || (s1_char_r == hiap_pkg::CH_CR) ||
                    (s1_char_r == hiap_pkg::CH_SPACE);
  assign digit    = 4'(s1_char_r - hiap_pkg::CH_ZERO);
  assign prod     = {st_r.mag, 3'b000} + {2'b00, st_r.mag, 1'b0} +
                    {{(hiap_pkg::PROD_W-4){1'b0}}, digit};

  always_comb begin
    st_dig = st_r;
    st_dig.phase = hiap_pkg::PH_DIGITS;
    if (st_r.ovf || (prod > hiap_pkg::SAT_LIMIT)) begin
      st_dig.ovf = 1'b1;
      st_dig.mag = hiap_pkg::SAT_MAG;
    end else begin
      st_dig.mag = prod[hiap_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    st_upd = st_r;
    if (s1_cvalid_r) begin
      case (st_r.phase)
        hiap_pkg::PH_SPACE: begin
          if (is_space) begin
            st_upd = st_r;
          end else if (s1_char_r == hiap_pkg::CH_MINUS) begin
            st_upd.neg   = 1'b1;
            st_upd.phase = hiap_pkg::PH_SIGN;
          end else if (s1_char_r == hiap_pkg::CH_PLUS) begin
            st_upd.phase = hiap_pkg::PH_SIGN;
          end else if (num_char) begin
            st_upd = st_dig;
          end else begin
            st_upd.phase = hiap_pkg::PH_FAIL;
          end
        end
        hiap_pkg::PH_SIGN: begin
          if (num_char) begin
            st_upd = st_dig;
          end else begin
            st_upd.phase = hiap_pkg::PH_FAIL;
          end
        end
        hiap_pkg::PH_DIGITS: begin
          if (num_char) begin
            st_upd = st_dig;
          end else begin
            st_upd.phase = hiap_pkg::PH_DONE;
          end
        end
        default: st_upd = st_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    st_nxt        = st_r;
    fin_nxt       = fin_r;
    fin_valid_nxt = fin_take ? 1'b0 : fin_valid_r;
    if (s1_go) begin
      if (s1_last_r) begin
        st_nxt.phase  = hiap_pkg::PH_SPACE;
        st_nxt.neg    = 1'b0;
        st_nxt.mag    = '0;
        st_nxt.ovf    = 1'b0;
        fin_nxt.st    = st_upd;
        fin_nxt.present = s1_present_r;
        fin_valid_nxt = 1'b1;
      end else begin
        st_nxt = st_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      st_r.phase  <= hiap_pkg::PH_SPACE;
      st_r.neg    <= 1'b0;
      st_r.mag    <= '0;
      st_r.ovf    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fin_valid_r <= fin_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r    <= in_tdata;
      s1_cvalid_r  <= in_tuser[0];
      s1_present_r <= in_tuser[1];
      s1_last_r    <= in_tlast;
    end
    fin_r <= fin_nxt;
  end

endmodule

@@ sv/hiap_judge.sv @@
// Applies the configured integer kind to a finished parse and holds the result beat.
module hiap_judge (
  input  logic            clk,
  input  logic            rst_n,
  input  hiap_pkg::fin_t  fin,
  input  logic            fin_valid,
  output logic            fin_ready,
  input  hiap_pkg::cfg_t  cfg,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // [31:0] result_value
  output logic            out_tuser   // [0] took_fallback
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] data_r;
  logic        fb_r;
  logic        load;
  logic        parsed, neg, ok;
  logic [31:0] val, mag, cmin32, cmax32, clamped;

  assign mag    = fin.st.mag;
  assign parsed = (fin.st.phase == hiap_pkg::PH_DIGITS) || (fin.st.phase == hiap_pkg::PH_DONE);
  assign neg    = fin.st.neg && (mag != '0);
  assign cmin32 = {1'b0, cfg.cmin};
  assign cmax32 = {1'b0, cfg.cmax};

  always_comb begin
    clamped = mag;
    if (mag < cmin32) begin
      clamped = cmin32;
    end
    if (clamped > cmax32) begin
      clamped = cmax32;
    end
  end

  always_comb begin
    ok  = 1'b0;
    val = mag;
    case (cfg.kind)
      hiap_pkg::KIND_LONG: begin
        ok  = !fin.st.ovf && (neg || !mag[31]);
        val = neg ? (~mag + 32'd1) : mag;
      end
      hiap_pkg::KIND_LIMITED_LONG, hiap_pkg::KIND_UNSIGNED: begin
        ok = !neg && !fin.st.ovf && !mag[31];
      end
      hiap_pkg::KIND_LIMITED_UNSIGNED, hiap_pkg::KIND_FALLBACK_UNSIGNED: begin
        ok = !neg && !fin.st.ovf && !mag[31] && (mag != '0);
      end
      hiap_pkg::KIND_CLAMPED_UNSIGNED: begin
        ok  = !neg;
        val = clamped;
      end
      default: ok = 1'b0;
    endcase
    ok = ok && parsed && fin.present;
  end

  assign fin_ready = !out_valid_r || out_tready;
  assign load      = fin_valid && fin_ready;

  always_comb begin
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= ok ? val : cfg.fallback;
      fb_r   <= !ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = fb_r;

endmodule

@@ sv/html_integer_attribute_parser_top.sv @@
// Top level: configuration registers, byte parser and kind judge of the HTML integer parser.
// A tlast beat goes through the input, finished-parse and result registers to out_tvalid.
// Throughput: one input beat per cycle until a stalled output holds up a tlast beat;
// the parse state loop is one byte per cycle. Only a beat marked tlast yields a result.
// Reset (rst_n low, synchronous) clears the parse state and pipeline valids and
// restores the registers to kind long, fallback 0, clamp 0 to 2^31-1.
module html_integer_attribute_parser_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] char_code
  input  logic [1:0]                       in_tuser,   // [0] char_valid, [1] attribute_present
  input  logic                             in_tlast,   // is_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] result_value
  output logic                             out_tuser,  // [0] took_fallback
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hiap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  hiap_pkg::cfg_t cfg_r, cfg_nxt;
  hiap_pkg::fin_t fin;
  logic           fin_valid, fin_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        hiap_pkg::REG_NUMBER_KIND:    cfg_nxt.kind     = cfg_data[2:0];
        hiap_pkg::REG_FALLBACK_VALUE: cfg_nxt.fallback = cfg_data;
        hiap_pkg::REG_CLAMP_MINIMUM:  cfg_nxt.cmin     = cfg_data[30:0];
        hiap_pkg::REG_CLAMP_MAXIMUM:  cfg_nxt.cmax     = cfg_data[30:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind     <= hiap_pkg::KIND_LONG;
      cfg_r.fallback <= '0;
      cfg_r.cmin     <= '0;
      cfg_r.cmax     <= hiap_pkg::CLAMP_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hiap_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .fin_r       (fin),
    .fin_valid_r (fin_valid),
    .fin_ready   (fin_ready)
  );

  hiap_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin        (fin),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
